FILE: design/bss_pkg.sv
package bss_pkg;

  localparam int MAX_COUNT   = 64;
  localparam int CNT_W       = $clog2(MAX_COUNT + 1);
  localparam int SUM_W       = 8 + $clog2(MAX_COUNT);
  localparam int STEP_W      = $clog2(SUM_W + 1);
  localparam int COUNT_OUT_W = 7;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]             median;
    logic [7:0]             mean;
    logic [7:0]             maximum;
    logic [7:0]             minimum;
    logic [COUNT_OUT_W-1:0] count;
    logic                   overflow;
  } out_t;

  // One classified transaction as it travels from front to back.
  typedef struct packed {
    logic [7:0] sample;
    logic       last;
    logic       drop;
  } entry_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic   empty;
    entry_t head;
  } q_stat_t;

endpackage

FILE: design/bss_front.sv
module bss_front
  import bss_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  in_t    in_i,
  input  logic   full_i,
  output logic   push_o,
  output entry_t entry_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop;

  // The store fills in arrival order, so the front can tell which bytes fit.
  assign drop   = (cnt_q == CNT_W'(MAX_COUNT));
  assign push_o = start_i && !full_i;

  assign entry_o.sample = in_i.sample;
  assign entry_o.last   = in_i.last;
  assign entry_o.drop   = drop;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (in_i.last) begin
        cnt_d = '0;
      end else if (!drop) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/bss_fifo.sv
module bss_fifo
  import bss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  input  logic    pop_i,
  output logic    full_o,
  output q_stat_t stat_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   fill_q;

  assign full_o       = (fill_q == (QPTR_W + 1)'(QDEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign stat_o.head  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (QPTR_W + 1)'(1);
        2'b01:   fill_q <= fill_q - (QPTR_W + 1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

FILE: design/bss_div.sv
module bss_div
  import bss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [7:0]       quot_o
);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [CNT_W:0]    trial;
  logic              ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_d = ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
  assign quo_d = {quo_q[SUM_W-2:0], ge};

  assign busy_o = busy_q;
  assign quot_o = quo_q[7:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(SUM_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

FILE: design/bss_back.sv
module bss_back
  import bss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t stat_i,
  output logic    pop_o,
  output logic    done_o,
  output out_t    res_o
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]       state_q;
  logic [7:0]       cell_q [MAX_COUNT];
  logic [7:0]       cell_d [MAX_COUNT];
  logic [MAX_COUNT-1:0] gt;
  logic [CNT_W-1:0] cnt_q, sh_q, half, sh_init;
  logic [SUM_W-1:0] sum_q;
  logic [7:0]       max_q, min_q, v, med, mean;
  logic             drop_q, ins, div_start, div_busy, finish;
  out_t             res_q;
  logic             done_q;

  assign v     = stat_i.head.sample;
  assign pop_o = (state_q == ST_RUN) && !stat_i.empty;
  assign ins   = pop_o && !stat_i.head.drop;

  // Ascending row of cells; each cell looks only at itself and its two neighbors.
  always_comb begin
    for (int i = 0; i < MAX_COUNT; i++) begin
      gt[i] = (CNT_W'(i) < cnt_q) && (cell_q[i] > v);
    end
    for (int i = 0; i < MAX_COUNT; i++) begin
      cell_d[i] = cell_q[i];
      if (ins && (gt[i] || CNT_W'(i) == cnt_q)) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end else begin
          cell_d[i] = v;
        end
      end else if (state_q == ST_WAIT && sh_q != '0 && i < MAX_COUNT - 1) begin
        // drain toward cell 0 until the middle pair sits at the bottom
        cell_d[i] = cell_q[(i < MAX_COUNT - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_COUNT; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  assign half      = cnt_q >> 1;
  assign sh_init   = cnt_q[0] ? half : half - CNT_W'(1);
  assign div_start = (state_q == ST_SETUP);
  assign finish    = (state_q == ST_WAIT) && (sh_q == '0) && !div_busy;
  assign med       = cnt_q[0] ? cell_q[0]
                              : 8'((9'(cell_q[0]) + 9'(cell_q[1])) >> 1);

  bss_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (cnt_q),
    .busy_o    (div_busy),
    .quot_o    (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
      sum_q   <= '0;
      drop_q  <= 1'b0;
      sh_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= finish;
      case (state_q)
        ST_RUN: begin
          if (pop_o) begin
            if (stat_i.head.drop) begin
              drop_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
              sum_q <= sum_q + SUM_W'(v);
            end
            if (stat_i.head.last) begin
              state_q <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          sh_q    <= sh_init;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sh_q != '0) begin
            sh_q <= sh_q - CNT_W'(1);
          end
          if (finish) begin
            cnt_q   <= '0;
            sum_q   <= '0;
            drop_q  <= 1'b0;
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  // Running extremes and the result register carry no reset.
  always_ff @(posedge clk_i) begin
    if (ins) begin
      if (cnt_q == '0 || v > max_q) begin
        max_q <= v;
      end
      if (cnt_q == '0 || v < min_q) begin
        min_q <= v;
      end
    end
    if (finish) begin
      res_q.median   <= med;
      res_q.mean     <= mean;
      res_q.maximum  <= max_q;
      res_q.minimum  <= min_q;
      res_q.count    <= COUNT_OUT_W'(cnt_q);
      res_q.overflow <= drop_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: design/byte_set_statistics_top.sv
// Byte set statistics. Send one unsigned byte per transaction on in_i with
// start high; the transaction is taken at a rising edge where busy is low,
// and in_i.last marks the final byte of a set. Bytes land in a 4-deep queue
// and are inserted into a sorted row of 64 cells at one byte per cycle, so a
// stream of non-final bytes runs at one per cycle while the back end is not
// finishing an earlier set. After the final byte the back end runs the
// bit-serial mean divider alongside the drain of the sorted row to its middle
// pair and then shows one result on res_o with done_o high for exactly one
// cycle; the receiver cannot stall it, so capture it on that cycle. Meanwhile
// busy rises only when the queue fills. Bytes beyond 64 in a set are dropped
// and reported through res_o.overflow; the store clears itself after each result.
module byte_set_statistics_top
  import bss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  in_i,
  output logic busy,
  output logic done_o,
  output out_t res_o
);

  logic    push, pop, full;
  entry_t  entry;
  q_stat_t q_stat;

  // Front: take the transaction and tag bytes that will not fit.
  bss_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .entry_o(entry)
  );

  // Queue: decouple acceptance from the sort and the final computation.
  bss_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .full_o (full),
    .stat_o (q_stat)
  );

  // Back: insert, accumulate, and produce the set's statistics.
  bss_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(q_stat),
    .pop_o (pop),
    .done_o(done_o),
    .res_o (res_o)
  );

  // Hold off new transactions only while the queue is full.
  assign busy = full;

endmodule

FILE: design/bss_checker.sv
module bss_checker
  import bss_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input in_t  in_i,
  input logic busy,
  input logic done_o,
  input out_t res_o
);

  // No result while reset is applied.
  a_no_done_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !done_o)
    else $error("result strobe during reset");

  // Results are single-cycle strobes, never back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A set always holds at least one byte.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.count != '0)
    else $error("result with empty count");

  // Median and mean lie between the extremes.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.minimum <= res_o.median) && (res_o.median <= res_o.maximum)
            && (res_o.minimum <= res_o.mean) && (res_o.mean <= res_o.maximum))
    else $error("statistics out of order");

  // An offered transaction and the busy flag are known while start is high.
  a_input_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !$isunknown({busy, in_i}))
    else $error("unknown busy or transaction while start is high");

endmodule

bind byte_set_statistics_top bss_checker u_bss_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .in_i  (in_i),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);
